// File: rtl/agst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agst_pkg
// Shared types and codes for the goal lifecycle transition decoder.
// ---------------------------------------------------------------------------
package agst_pkg;

    // lifecycle states
    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_CANCEL  = 2'd1;
    localparam logic [1:0] ST_FINISH  = 2'd2;

    // cancel origins
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_CLIENT  = 2'd1;
    localparam logic [1:0] SRC_RUNTIME = 2'd2;

    // terminal status
    localparam logic [1:0] FS_UNSPEC = 2'd0;
    localparam logic [1:0] FS_SUCC   = 2'd1;
    localparam logic [1:0] FS_CANC   = 2'd2;
    localparam logic [1:0] FS_ABORT  = 2'd3;

    // outcome
    localparam logic [1:0] OUT_NOP   = 2'd0;
    localparam logic [1:0] OUT_TRANS = 2'd1;
    localparam logic [1:0] OUT_ERR   = 2'd2;

    // fault codes
    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_CTX     = 3'd1;
    localparam logic [2:0] F_NOTALL  = 3'd2;
    localparam logic [2:0] F_NOPEND  = 3'd3;
    localparam logic [2:0] F_STATUS  = 3'd4;
    localparam logic [2:0] F_UNKNOWN = 3'd5;

    // event codes
    localparam logic [4:0] EV_FEEDBACK        = 5'd0;
    localparam logic [4:0] EV_DONE_SUCC       = 5'd1;
    localparam logic [4:0] EV_DONE_CANC       = 5'd2;
    localparam logic [4:0] EV_DONE_ABORT      = 5'd3;
    localparam logic [4:0] EV_DONE_UNSPEC     = 5'd4;
    localparam logic [4:0] EV_ACCEPT_CANCEL   = 5'd5;
    localparam logic [4:0] EV_REJECT_CANCEL   = 5'd6;
    localparam logic [4:0] EV_CANCEL_REQ      = 5'd7;
    localparam logic [4:0] EV_DUP_CANCEL      = 5'd8;
    localparam logic [4:0] EV_DUP_GOAL        = 5'd9;
    localparam logic [4:0] EV_FB_SENT         = 5'd10;
    localparam logic [4:0] EV_FB_FAILED       = 5'd11;
    localparam logic [4:0] EV_RESULT_SENT     = 5'd12;
    localparam logic [4:0] EV_RESULT_FAILED   = 5'd13;
    localparam logic [4:0] EV_DISCONNECT      = 5'd14;
    localparam logic [4:0] EV_APP_TIMEOUT     = 5'd15;
    localparam logic [4:0] EV_SHUTDOWN        = 5'd16;
    localparam logic [4:0] EV_RUNTIME_CANCEL  = 5'd17;

    typedef struct packed {
        logic [1:0] goal_state;
        logic       cancel_pending;
        logic [1:0] cancel_source;
        logic [1:0] final_status;
    } t_goal_ctx;

    typedef struct packed {
        logic [1:0] outcome;
        logic [2:0] fault_code;
        t_goal_ctx  next_ctx;
    } t_dec_result;

endpackage

// File: rtl/agst_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agst_decode
// Combinational event decode: context check, transition and fault selection.
// ---------------------------------------------------------------------------
module agst_decode (
    input  agst_pkg::t_goal_ctx   i_ctx,
    input  logic [4:0]            i_kind,
    output agst_pkg::t_dec_result o_res
);
    import agst_pkg::*;

    logic       w_ctx_ok;
    logic [1:0] w_st;
    logic       w_pend;
    logic [1:0] w_src;
    logic [1:0] w_fs;
    logic       w_done_ok;

    assign w_st   = i_ctx.goal_state;
    assign w_pend = i_ctx.cancel_pending;
    assign w_src  = i_ctx.cancel_source;
    assign w_fs   = i_ctx.final_status;

    // state 0..2, pending tracks origin, pending only while executing,
    // status set exactly when finishing
    assign w_ctx_ok = (w_st <= ST_FINISH)
                   && (w_pend == (w_src != SRC_NONE))
                   && !(w_pend && (w_st != ST_EXEC))
                   && ((w_st == ST_FINISH) ? (w_fs != FS_UNSPEC) : (w_fs == FS_UNSPEC));

    // completion codes 1..3 carry the wanted status in their low bits
    assign w_done_ok = ((w_st == ST_EXEC)
                        && ((i_kind[1:0] == FS_SUCC) || (i_kind[1:0] == FS_ABORT)))
                    || ((w_st == ST_CANCEL)
                        && ((i_kind[1:0] == FS_CANC) || (i_kind[1:0] == FS_ABORT)));

    always_comb begin
        o_res.outcome    = OUT_NOP;
        o_res.fault_code = F_NONE;
        o_res.next_ctx   = i_ctx;
        if (!w_ctx_ok) begin
            o_res.outcome    = OUT_ERR;
            o_res.fault_code = F_CTX;
        end else begin
            unique case (i_kind)
                EV_FEEDBACK: begin
                    if (w_st != ST_EXEC && w_st != ST_CANCEL) begin
                        o_res.outcome    = OUT_ERR;
                        o_res.fault_code = F_NOTALL;
                    end
                end
                EV_DONE_SUCC, EV_DONE_CANC, EV_DONE_ABORT: begin
                    if (!w_done_ok) begin
                        o_res.outcome    = OUT_ERR;
                        o_res.fault_code = F_NOTALL;
                    end else begin
                        o_res.outcome                 = OUT_TRANS;
                        o_res.next_ctx.goal_state     = ST_FINISH;
                        o_res.next_ctx.cancel_pending = 1'b0;
                        o_res.next_ctx.cancel_source  = SRC_NONE;
                        o_res.next_ctx.final_status   = i_kind[1:0];
                    end
                end
                EV_DONE_UNSPEC: begin
                    o_res.outcome    = OUT_ERR;
                    o_res.fault_code = F_STATUS;
                end
                EV_ACCEPT_CANCEL, EV_REJECT_CANCEL: begin
                    if (w_st != ST_EXEC) begin
                        o_res.outcome    = OUT_ERR;
                        o_res.fault_code = F_NOTALL;
                    end else if (!w_pend || (w_src == SRC_NONE)) begin
                        o_res.outcome    = OUT_ERR;
                        o_res.fault_code = F_NOPEND;
                    end else begin
                        o_res.outcome                 = OUT_TRANS;
                        o_res.next_ctx.goal_state     =
                            (i_kind == EV_ACCEPT_CANCEL) ? ST_CANCEL : ST_EXEC;
                        o_res.next_ctx.cancel_pending = 1'b0;
                        o_res.next_ctx.cancel_source  = SRC_NONE;
                    end
                end
                EV_CANCEL_REQ: begin
                    if (w_st == ST_EXEC && !w_pend) begin
                        o_res.outcome                 = OUT_TRANS;
                        o_res.next_ctx.cancel_pending = 1'b1;
                        o_res.next_ctx.cancel_source  = SRC_CLIENT;
                    end
                end
                EV_RESULT_SENT, EV_RESULT_FAILED: begin
                    if (w_st != ST_FINISH) begin
                        o_res.outcome    = OUT_ERR;
                        o_res.fault_code = F_NOTALL;
                    end
                end
                EV_DUP_CANCEL, EV_DUP_GOAL, EV_FB_SENT, EV_FB_FAILED,
                EV_DISCONNECT, EV_APP_TIMEOUT, EV_SHUTDOWN: begin
                    o_res.outcome = OUT_NOP;
                end
                EV_RUNTIME_CANCEL: begin
                    // runtime cancel marks a new cancel, or relabels a pending one from another origin
                    if (w_st == ST_EXEC) begin
                        if (!w_pend) begin
                            o_res.outcome                 = OUT_TRANS;
                            o_res.next_ctx.cancel_pending = 1'b1;
                            o_res.next_ctx.cancel_source  = SRC_RUNTIME;
                        end else if (w_src != SRC_RUNTIME) begin
                            o_res.outcome                = OUT_TRANS;
                            o_res.next_ctx.cancel_source = SRC_RUNTIME;
                        end
                    end
                end
                default: begin
                    o_res.outcome    = OUT_ERR;
                    o_res.fault_code = F_UNKNOWN;
                end
            endcase
        end
    end

endmodule

// File: rtl/action_goal_server_transition.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// action_goal_server_transition
// Server-side goal lifecycle transition decoder with registered in/out.
// ---------------------------------------------------------------------------
// Each input transaction carries one goal context and one event code and
// yields exactly one result transaction: outcome, fault code and the next
// context. The block holds no goal state of its own; the caller feeds the
// context back. The result passes the input register, then the result
// register, and throughput is one transaction per cycle while the result
// side is ready: the only work is a single combinational decode stage
// between the input register and the result register. Backpressure
// on the result side propagates through both registers, so input is still
// taken while a result waits as long as the input register has room or
// moves on in the same cycle.
module action_goal_server_transition (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] goal_state, [2] cancel_pending, [4:3] cancel_source,
    // [6:5] final_status, [7] zero
    input  logic [7:0]  s_axis_tdata,
    // [4:0] kind (event code)
    input  logic [4:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] outcome, [4:2] fault_code, [6:5] next_goal_state,
    // [7] next_cancel_pending, [9:8] next_cancel_source,
    // [11:10] next_final_status, [15:12] zero
    output logic [15:0] m_axis_tdata
);
    import agst_pkg::*;

    // input stage
    logic        r_in_valid, n_in_valid;
    t_goal_ctx   r_in_ctx,   n_in_ctx;
    logic [4:0]  r_in_kind,  n_in_kind;

    // result stage
    logic        r_out_valid, n_out_valid;
    t_dec_result r_out_res,   n_out_res;

    t_dec_result w_dec;
    logic        w_advance;   // input stage may hand over to result stage
    logic        w_take;      // input transaction accepted

    agst_decode u_decode (
        .i_ctx  (r_in_ctx),
        .i_kind (r_in_kind),
        .o_res  (w_dec)
    );

    // result register frees when empty or drained this cycle
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_ctx    = r_in_ctx;
        n_in_kind   = r_in_kind;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;

        if (w_advance) begin
            n_out_valid = r_in_valid;
            if (r_in_valid) begin
                n_out_res = w_dec;
            end
        end

        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
        if (w_take) begin
            n_in_ctx.goal_state     = s_axis_tdata[1:0];
            n_in_ctx.cancel_pending = s_axis_tdata[2];
            n_in_ctx.cancel_source  = s_axis_tdata[4:3];
            n_in_ctx.final_status   = s_axis_tdata[6:5];
            n_in_kind               = s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_in_ctx  <= n_in_ctx;
        r_in_kind <= n_in_kind;
        r_out_res <= n_out_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_out_res.next_ctx.final_status,
                            r_out_res.next_ctx.cancel_source,
                            r_out_res.next_ctx.cancel_pending,
                            r_out_res.next_ctx.goal_state,
                            r_out_res.fault_code,
                            r_out_res.outcome};

endmodule

// File: bench/tb_action_goal_server_transition.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_action_goal_server_transition
// Self-checking bench for the goal lifecycle transition decoder.
// ---------------------------------------------------------------------------
// A short table of directed transactions is followed by chained random goal
// lifecycles. Each accepted input is run through a local transition predictor
// and the result is queued. Every result transaction is compared field by
// field with the oldest queued result. Both stream sides idle at random in
// two of the three phases, and the result side also holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_action_goal_server_transition;
    import agst_pkg::*;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS    = 450;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] goal_state, [2] cancel_pending, [4:3] cancel_source,
    // [6:5] final_status, [7] zero
    logic [7:0]  s_axis_tdata = '0;
    // [4:0] kind (event code)
    logic [4:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] outcome, [4:2] fault_code, [6:5] next_goal_state,
    // [7] next_cancel_pending, [9:8] next_cancel_source,
    // [11:10] next_final_status, [15:12] zero
    logic [15:0] m_axis_tdata;

    // Directed row: input context, event, and for rows whose answer is an
    // obvious error, the outcome and fault typed in (next context = input).
    typedef struct packed {
        t_goal_ctx  ctx;
        logic [4:0] ev;
        logic       pinned;
        logic [1:0] outcome;
        logic [2:0] fault;
    } t_dir_row;

    t_dir_row    dir_rows[$];
    t_dec_result expected_results[$];
    t_goal_ctx   goal_trace;      // running context of the chained lifecycle
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;
    int unsigned rx_hold_count = 0;
    int unsigned mismatches = 0;

    action_goal_server_transition i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Transition predictor: context check first, then per-event rules.
    // Fields are only changed on a transition, so errors and no-ops hand
    // back the input context untouched.
    function automatic t_dec_result predict_transition(input t_goal_ctx c,
                                                       input logic [4:0] ev);
        t_dec_result r;
        logic        ctx_sane;
        logic        done_ok;
        r.outcome    = OUT_NOP;
        r.fault_code = F_NONE;
        r.next_ctx   = c;
        // only "origin present" is tied to pending; origin 3 passes as any
        ctx_sane = (c.goal_state <= ST_FINISH)
                && (c.cancel_pending == (c.cancel_source != SRC_NONE))
                && !(c.cancel_pending && c.goal_state != ST_EXEC)
                && ((c.goal_state == ST_FINISH) == (c.final_status != FS_UNSPEC));
        if (!ctx_sane) begin
            r.outcome    = OUT_ERR;
            r.fault_code = F_CTX;
        end else begin
            case (ev)
                EV_FEEDBACK: begin
                    if (c.goal_state == ST_FINISH) begin
                        r.outcome    = OUT_ERR;
                        r.fault_code = F_NOTALL;
                    end
                end
                EV_DONE_SUCC, EV_DONE_CANC, EV_DONE_ABORT: begin
                    done_ok = (c.goal_state == ST_EXEC && ev != EV_DONE_CANC)
                           || (c.goal_state == ST_CANCEL && ev != EV_DONE_SUCC);
                    if (!done_ok) begin
                        r.outcome    = OUT_ERR;
                        r.fault_code = F_NOTALL;
                    end else begin
                        r.outcome                 = OUT_TRANS;
                        r.next_ctx.goal_state     = ST_FINISH;
                        r.next_ctx.cancel_pending = 1'b0;
                        r.next_ctx.cancel_source  = SRC_NONE;
                        r.next_ctx.final_status   = (ev == EV_DONE_SUCC) ? FS_SUCC :
                                                    (ev == EV_DONE_CANC) ? FS_CANC :
                                                                           FS_ABORT;
                    end
                end
                EV_DONE_UNSPEC: begin
                    r.outcome    = OUT_ERR;
                    r.fault_code = F_STATUS;
                end
                EV_ACCEPT_CANCEL, EV_REJECT_CANCEL: begin
                    if (c.goal_state != ST_EXEC) begin
                        r.outcome    = OUT_ERR;
                        r.fault_code = F_NOTALL;
                    end else if (!c.cancel_pending || c.cancel_source == SRC_NONE) begin
                        r.outcome    = OUT_ERR;
                        r.fault_code = F_NOPEND;
                    end else begin
                        r.outcome                 = OUT_TRANS;
                        r.next_ctx.goal_state     = (ev == EV_ACCEPT_CANCEL) ? ST_CANCEL
                                                                            : ST_EXEC;
                        r.next_ctx.cancel_pending = 1'b0;
                        r.next_ctx.cancel_source  = SRC_NONE;
                    end
                end
                EV_CANCEL_REQ: begin
                    if (c.goal_state == ST_EXEC && !c.cancel_pending) begin
                        r.outcome                 = OUT_TRANS;
                        r.next_ctx.cancel_pending = 1'b1;
                        r.next_ctx.cancel_source  = SRC_CLIENT;
                    end
                end
                EV_RESULT_SENT, EV_RESULT_FAILED: begin
                    if (c.goal_state != ST_FINISH) begin
                        r.outcome    = OUT_ERR;
                        r.fault_code = F_NOTALL;
                    end
                end
                EV_DUP_CANCEL, EV_DUP_GOAL, EV_FB_SENT, EV_FB_FAILED,
                EV_DISCONNECT, EV_APP_TIMEOUT, EV_SHUTDOWN: begin
                end
                EV_RUNTIME_CANCEL: begin
                    // marks a new decision, or relabels a pending one
                    if (c.goal_state == ST_EXEC && c.cancel_source != SRC_RUNTIME) begin
                        r.outcome                 = OUT_TRANS;
                        r.next_ctx.cancel_pending = 1'b1;
                        r.next_ctx.cancel_source  = SRC_RUNTIME;
                    end
                end
                default: begin
                    r.outcome    = OUT_ERR;
                    r.fault_code = F_UNKNOWN;
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_goal_ctx random_valid_goal();
        t_goal_ctx c;
        c = '{goal_state: ST_EXEC, cancel_pending: 1'b0, cancel_source: SRC_NONE,
              final_status: FS_UNSPEC};
        case ($urandom_range(5))
            0: ;
            1: begin c.cancel_pending = 1'b1; c.cancel_source = SRC_CLIENT;  end
            2: begin c.cancel_pending = 1'b1; c.cancel_source = SRC_RUNTIME; end
            3: begin c.cancel_pending = 1'b1; c.cancel_source = 2'd3;        end
            4: c.goal_state = ST_CANCEL;
            default: begin
                c.goal_state   = ST_FINISH;
                c.final_status = 2'($urandom_range(3, 1));
            end
        endcase
        return c;
    endfunction

    task automatic add_row(input logic [1:0] st, input logic pend, input logic [1:0] src,
                           input logic [1:0] fs, input logic [4:0] ev, input logic pinned,
                           input logic [1:0] outcome, input logic [2:0] fault);
        t_dir_row row;
        row.ctx     = '{goal_state: st, cancel_pending: pend, cancel_source: src,
                        final_status: fs};
        row.ev      = ev;
        row.pinned  = pinned;
        row.outcome = outcome;
        row.fault   = fault;
        dir_rows.push_back(row);
    endtask

    // Offer one transaction; queue its result once it is taken.
    task automatic send_goal_event(input t_goal_ctx c, input logic [4:0] ev,
                                   input t_dec_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, c.final_status, c.cancel_source, c.cancel_pending,
                          c.goal_state};
        s_axis_tuser  <= ev;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(want);
    endtask

    // Mostly chained lifecycles fed back from the predictor, some fresh
    // legal contexts, some raw noise; events mostly from the known list.
    task automatic run_random_phase(input int unsigned n);
        t_goal_ctx   c;
        logic [4:0]  ev;
        t_dec_result want;
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                c = t_goal_ctx'(7'($urandom_range(127)));
            end else if (pick < 30) begin
                c = random_valid_goal();
            end else begin
                // finished goals are retired now and then for a fresh one
                if (goal_trace.goal_state == ST_FINISH && $urandom_range(1) == 0)
                    goal_trace = '{goal_state: ST_EXEC, cancel_pending: 1'b0,
                                   cancel_source: SRC_NONE, final_status: FS_UNSPEC};
                c = goal_trace;
            end
            ev   = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                            : 5'($urandom_range(17));
            want = predict_transition(c, ev);
            if (pick >= 15)
                goal_trace = want.next_ctx;
            send_goal_event(c, ev, want);
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Result side ready: random per cycle, or held low for a long stretch
    // once requested so that both pipeline registers fill up.
    always @(negedge i_clk) begin
        if (rx_hold_req && rx_hold_count < RX_HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : result_monitor
        t_dec_result got;
        t_dec_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.outcome                 = m_axis_tdata[1:0];
            got.fault_code              = m_axis_tdata[4:2];
            got.next_ctx.goal_state     = m_axis_tdata[6:5];
            got.next_ctx.cancel_pending = m_axis_tdata[7];
            got.next_ctx.cancel_source  = m_axis_tdata[9:8];
            got.next_ctx.final_status   = m_axis_tdata[11:10];
            if (expected_results.size() == 0) begin
                $error("result transaction with no expectation: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(got.outcome));
                check_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
                check_field("next_goal_state", 32'(want.next_ctx.goal_state),
                            32'(got.next_ctx.goal_state));
                check_field("next_cancel_pending", 32'(want.next_ctx.cancel_pending),
                            32'(got.next_ctx.cancel_pending));
                check_field("next_cancel_source", 32'(want.next_ctx.cancel_source),
                            32'(got.next_ctx.cancel_source));
                check_field("next_final_status", 32'(want.next_ctx.final_status),
                            32'(got.next_ctx.final_status));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_dec_result want;
        int unsigned drain_cycles;

        // contexts the decoder must refuse
        add_row(2'd3, 1'b0, SRC_NONE, FS_UNSPEC, EV_FEEDBACK, 1'b1, OUT_ERR, F_CTX);
        add_row(2'd3, 1'b1, 2'd3, FS_ABORT, 5'd31, 1'b1, OUT_ERR, F_CTX);
        add_row(ST_EXEC, 1'b1, SRC_NONE, FS_UNSPEC, EV_CANCEL_REQ, 1'b1, OUT_ERR, F_CTX);
        add_row(ST_CANCEL, 1'b1, SRC_CLIENT, FS_UNSPEC, EV_ACCEPT_CANCEL, 1'b1,
                OUT_ERR, F_CTX);
        add_row(ST_FINISH, 1'b0, SRC_NONE, FS_UNSPEC, EV_RESULT_SENT, 1'b1, OUT_ERR, F_CTX);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_SUCC, EV_FEEDBACK, 1'b1, OUT_ERR, F_CTX);
        // completion
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_FEEDBACK, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_DONE_SUCC, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_CANCEL, 1'b0, SRC_NONE, FS_UNSPEC, EV_DONE_CANC, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_CANCEL, 1'b0, SRC_NONE, FS_UNSPEC, EV_DONE_ABORT, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_DONE_CANC, 1'b1, OUT_ERR, F_NOTALL);
        add_row(ST_FINISH, 1'b0, SRC_NONE, FS_SUCC, EV_DONE_UNSPEC, 1'b1, OUT_ERR, F_STATUS);
        // cancel decisions, including the out-of-range origin; cancel request and no-op events
        add_row(ST_EXEC, 1'b1, SRC_CLIENT, FS_UNSPEC, EV_ACCEPT_CANCEL, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b1, 2'd3, FS_UNSPEC, EV_REJECT_CANCEL, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_ACCEPT_CANCEL, 1'b1, OUT_ERR, F_NOPEND);
        add_row(ST_CANCEL, 1'b0, SRC_NONE, FS_UNSPEC, EV_REJECT_CANCEL, 1'b1,
                OUT_ERR, F_NOTALL);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_CANCEL_REQ, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b1, SRC_CLIENT, FS_UNSPEC, EV_DUP_CANCEL, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b1, SRC_RUNTIME, FS_UNSPEC, EV_DUP_GOAL, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_CANCEL, 1'b0, SRC_NONE, FS_UNSPEC, EV_FB_SENT, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_FINISH, 1'b0, SRC_NONE, FS_SUCC, EV_FB_FAILED, 1'b0, OUT_NOP, F_NONE);
        // feedback after finishing, result send before and after finishing, no-op events
        add_row(ST_FINISH, 1'b0, SRC_NONE, FS_ABORT, EV_FEEDBACK, 1'b1, OUT_ERR, F_NOTALL);
        add_row(ST_CANCEL, 1'b0, SRC_NONE, FS_UNSPEC, EV_RESULT_FAILED, 1'b1,
                OUT_ERR, F_NOTALL);
        add_row(ST_FINISH, 1'b0, SRC_NONE, FS_CANC, EV_RESULT_SENT, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_DISCONNECT, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_CANCEL, 1'b0, SRC_NONE, FS_UNSPEC, EV_APP_TIMEOUT, 1'b0, OUT_NOP, F_NONE);
        add_row(ST_FINISH, 1'b0, SRC_NONE, FS_ABORT, EV_SHUTDOWN, 1'b0, OUT_NOP, F_NONE);
        // runtime cancel: relabel a client cancel, no-op on its own, fresh mark
        add_row(ST_EXEC, 1'b1, SRC_CLIENT, FS_UNSPEC, EV_RUNTIME_CANCEL, 1'b0,
                OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b1, SRC_RUNTIME, FS_UNSPEC, EV_RUNTIME_CANCEL, 1'b0,
                OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, EV_RUNTIME_CANCEL, 1'b0,
                OUT_NOP, F_NONE);
        add_row(ST_EXEC, 1'b0, SRC_NONE, FS_UNSPEC, 5'd18, 1'b1, OUT_ERR, F_UNKNOWN);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].pinned) begin
                want.outcome    = dir_rows[k].outcome;
                want.fault_code = dir_rows[k].fault;
                want.next_ctx   = dir_rows[k].ctx;
            end else begin
                want = predict_transition(dir_rows[k].ctx, dir_rows[k].ev);
            end
            send_goal_event(dir_rows[k].ctx, dir_rows[k].ev, want);
        end

        goal_trace = '{goal_state: ST_EXEC, cancel_pending: 1'b0, cancel_source: SRC_NONE,
                       final_status: FS_UNSPEC};

        // eager sender, mostly stalled receiver; then the reverse
        tx_idle_pct = 29;
        rx_idle_pct = 80;
        run_random_phase(PHASE_ITEMS);
        tx_idle_pct = 80;
        rx_idle_pct = 29;
        run_random_phase(PHASE_ITEMS);

        // full rate, opened by a long receiver hold-off while items keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        run_random_phase(PHASE_ITEMS);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        // the drain_cycles spare cycles after the last result catch stray results
        drain_cycles = 10;
        repeat (drain_cycles) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
